@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------
// assertion macros
// shared wrappers for clocked concurrent assertions
// ----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_ALW(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

@@ rtl/core/lfa_pkg.sv @@
// ----------------------------------------------------------------------
// lfa_pkg
// types, constants and lookup functions of the lora frame airtime block
// ----------------------------------------------------------------------
package lfa_pkg;

   // field widths of the request and response beats
   localparam int SF_W      = 4;
   localparam int BW_CODE_W = 4;
   localparam int CR_W      = 3;
   localparam int PRE_W     = 16;
   localparam int SYM_W     = 28;
   localparam int TIME_W    = 44;
   localparam int CNT_W     = 11;

   // datapath widths
   localparam int NUM_W      = 19;  // quarter symbols of a frame
   localparam int RAT_A_W    = 23;  // reduced 64e6 / bw numerator
   localparam int RAT_B_W    = 13;  // reduced 64e6 / bw denominator
   localparam int PROD_W     = NUM_W + RAT_A_W;
   localparam int DIVIDEND_W = PROD_W + 12;  // after shift by sf up to 12
   localparam int QUO_W      = 44;
   localparam int DIV_STEP   = 4;   // quotient bits per divider stage
   localparam int DIV_STAGES = QUO_W / DIV_STEP;
   localparam int BACK_LAT   = 2 + DIV_STAGES;
   localparam int BLK_W      = 8;

   // parameter limits
   localparam logic [SF_W-1:0] SF_MIN = 4'd5;
   localparam logic [SF_W-1:0] SF_MAX = 4'd12;
   localparam logic [CR_W-1:0] CR_MIN = 3'd1;
   localparam logic [CR_W-1:0] CR_MAX = 3'd4;

   // frame constants
   localparam int CR_BASE         = 4;   // coding rate 4/(4+cr)
   localparam int PAYLOAD_HEAD    = 8;   // fixed symbols before the blocks
   localparam int PREAMBLE_TAIL   = 17;  // 4.25 symbols in quarters
   localparam int SYMBOL_QUARTERS = 4;

   // bandwidth codes
   localparam logic [BW_CODE_W-1:0] BW_7K81   = 4'd0;
   localparam logic [BW_CODE_W-1:0] BW_15K63  = 4'd1;
   localparam logic [BW_CODE_W-1:0] BW_31K25  = 4'd2;
   localparam logic [BW_CODE_W-1:0] BW_62K5   = 4'd3;
   localparam logic [BW_CODE_W-1:0] BW_125K   = 4'd4;
   localparam logic [BW_CODE_W-1:0] BW_250K   = 4'd5;
   localparam logic [BW_CODE_W-1:0] BW_500K   = 4'd6;
   localparam logic [BW_CODE_W-1:0] BW_10K42  = 4'd8;
   localparam logic [BW_CODE_W-1:0] BW_20K83  = 4'd9;
   localparam logic [BW_CODE_W-1:0] BW_41K67  = 4'd10;

   typedef struct packed {
      logic [SF_W-1:0]      sf_code;
      logic [BW_CODE_W-1:0] bandwidth_code;
      logic [CR_W-1:0]      cr_code;
      logic [PRE_W-1:0]     preamble_symbols;
      logic                 header_term;
      logic                 low_rate_optimize;
   } lfa_req_type;

   typedef struct packed {
      logic [SYM_W-1:0]  symbol_time;
      logic [TIME_W-1:0] preamble_time;
      logic [TIME_W-1:0] frame_time;
      logic [CNT_W-1:0]  payload_symbol_count;
      logic              param_error;
   } lfa_rsp_type;

   // 64e6 / bw as a reduced fraction a / b
   typedef struct packed {
      logic               known;
      logic [RAT_A_W-1:0] num_a;
      logic [RAT_B_W-1:0] den_b;
   } lfa_ratio_type;

   // classified job handed from the front to the back
   typedef struct packed {
      logic [NUM_W-1:0]   pre_n;
      logic [NUM_W-1:0]   frame_n;
      logic [RAT_A_W-1:0] num_a;
      logic [RAT_B_W-1:0] den_b;
      logic [SF_W-1:0]    shift;
      logic [CNT_W-1:0]   count;
      logic               err;
   } lfa_job_type;

   // values that ride alongside the divider stages
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             err;
   } lfa_side_type;

   function automatic lfa_ratio_type lfa_bw_ratio(input logic [BW_CODE_W-1:0] code);
      lfa_ratio_type r;
      r = '{known: 1'b1, num_a: 23'd1, den_b: 13'd1};
      case (code)
         BW_7K81:  begin r.num_a = 23'd6400000; r.den_b = 13'd781;  end
         BW_15K63: begin r.num_a = 23'd6400000; r.den_b = 13'd1563; end
         BW_31K25: begin r.num_a = 23'd2048;    r.den_b = 13'd1;    end
         BW_62K5:  begin r.num_a = 23'd1024;    r.den_b = 13'd1;    end
         BW_125K:  begin r.num_a = 23'd512;     r.den_b = 13'd1;    end
         BW_250K:  begin r.num_a = 23'd256;     r.den_b = 13'd1;    end
         BW_500K:  begin r.num_a = 23'd128;     r.den_b = 13'd1;    end
         BW_10K42: begin r.num_a = 23'd3200000; r.den_b = 13'd521;  end
         BW_20K83: begin r.num_a = 23'd6400000; r.den_b = 13'd2083; end
         BW_41K67: begin r.num_a = 23'd6400000; r.den_b = 13'd4167; end
         default:  begin r.known = 1'b0; r.num_a = '0; r.den_b = 13'd1; end
      endcase
      return r;
   endfunction

   // pick by header flag and low data rate flag
   function automatic logic [BLK_W-1:0] lfa_pick4(
      input logic h, input logic l,
      input logic [BLK_W-1:0] v00, input logic [BLK_W-1:0] v01,
      input logic [BLK_W-1:0] v10, input logic [BLK_W-1:0] v11);
      logic [BLK_W-1:0] v;
      v = l ? (h ? v11 : v10) : (h ? v01 : v00);
      return v;
   endfunction

   // ceil(payload bits / bits per block) for the fixed 256 byte payload
   function automatic logic [BLK_W-1:0] lfa_payload_blocks(
      input logic [SF_W-1:0] sf, input logic h, input logic l);
      logic [BLK_W-1:0] b;
      case (sf)
         4'd5:    b = lfa_pick4(h, l, 8'd104, 8'd105, 8'd173, 8'd175);
         4'd6:    b = lfa_pick4(h, l, 8'd87,  8'd87,  8'd130, 8'd131);
         4'd7:    b = lfa_pick4(h, l, 8'd74,  8'd75,  8'd104, 8'd105);
         4'd8:    b = lfa_pick4(h, l, 8'd65,  8'd65,  8'd86,  8'd87);
         4'd9:    b = lfa_pick4(h, l, 8'd58,  8'd58,  8'd74,  8'd75);
         4'd10:   b = lfa_pick4(h, l, 8'd52,  8'd52,  8'd65,  8'd65);
         4'd11:   b = lfa_pick4(h, l, 8'd47,  8'd47,  8'd57,  8'd58);
         4'd12:   b = lfa_pick4(h, l, 8'd43,  8'd43,  8'd52,  8'd52);
         default: b = '0;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/core/lora_frame_airtime.sv @@
// ----------------------------------------------------------------------
// lora_frame_airtime
// symbol, preamble and 256 byte frame airtime of a lora link, in
// microseconds with 8 fraction bits, truncated
//
//   channel  dir  handshake              beat
//   req      in   req_valid, req_ready   lfa_req_type
//   rsp      out  rsp_valid, rsp_ready   lfa_rsp_type
//
// one beat per cycle sustained while rsp_ready stays high; each job
// passes the front register, a queue slot and 13 back stages, of which
// 11 are the divider pipeline at four quotient bits per stage.
// reset clears the valid flags, queue pointers and fill count only.
// rsp_ready low freezes the back; the queue takes QUEUE_DEPTH jobs and
// the front one more before req_ready drops.
// ----------------------------------------------------------------------
module lora_frame_airtime #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lfa_pkg::lfa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lfa_pkg::lfa_rsp_type rsp_data
);
   import lfa_pkg::*;

   logic        fq_valid, fq_ready;
   lfa_job_type fq_job;
   logic        qb_valid, qb_ready;
   lfa_job_type qb_job;

   // parameter check and job build
   lfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_job   (fq_job)
   );

   // decoupling queue
   lfa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_job   (qb_job)
   );

   // multiply and divide pipeline
   lfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_job    (qb_job),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

@@ rtl/core/lfa_div_lane.sv @@
// ----------------------------------------------------------------------
// lfa_div_lane
// one time lane: n * a * 2^sf / b, multiply, shift, then a pipelined
// restoring divider with four quotient bits per stage
// ----------------------------------------------------------------------
module lfa_div_lane (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [lfa_pkg::NUM_W-1:0]   num,
   input  logic [lfa_pkg::RAT_A_W-1:0] num_a,
   input  logic [lfa_pkg::RAT_B_W-1:0] den_b,
   input  logic [lfa_pkg::SF_W-1:0]    shift,
   output logic [lfa_pkg::QUO_W-1:0]   quotient
);
   import lfa_pkg::*;

   localparam int TOP_W = DIVIDEND_W - QUO_W;

   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [RAT_B_W-1:0]    den0_ff, den1_ff;
   logic [SF_W-1:0]       shift0_ff;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;

   logic [RAT_B_W-1:0] rem_ff  [DIV_STAGES];
   logic [RAT_B_W-1:0] rem_in  [DIV_STAGES];
   logic [QUO_W-1:0]   work_ff [DIV_STAGES];
   logic [QUO_W-1:0]   work_in [DIV_STAGES];
   logic [RAT_B_W-1:0] den_ff  [DIV_STAGES];
   logic [RAT_B_W-1:0] src_rem  [DIV_STAGES];
   logic [QUO_W-1:0]   src_work [DIV_STAGES];
   logic [RAT_B_W-1:0] src_den  [DIV_STAGES];

   // multiply and shift stages
   assign prod_in = num * num_a;
   assign dvd_in  = {{(DIVIDEND_W-PROD_W){1'b0}}, prod_ff} << shift0_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff   <= prod_in;
         den0_ff   <= den_b;
         shift0_ff <= shift;
         dvd_ff    <= dvd_in;
         den1_ff   <= den0_ff;
      end
   end

   // divider stages, the top dividend bits start as the partial remainder
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_rem[s]  = {{(RAT_B_W-TOP_W){1'b0}}, dvd_ff[DIVIDEND_W-1 -: TOP_W]};
         assign src_work[s] = dvd_ff[QUO_W-1:0];
         assign src_den[s]  = den1_ff;
      end else begin : g_next
         assign src_rem[s]  = rem_ff[s-1];
         assign src_work[s] = work_ff[s-1];
         assign src_den[s]  = den_ff[s-1];
      end

      always_comb begin
         logic [RAT_B_W:0]   trial;
         logic [RAT_B_W-1:0] r;
         logic [QUO_W-1:0]   w;
         r = src_rem[s];
         w = src_work[s];
         trial = '0;
         for (int k = 0; k < DIV_STEP; k++) begin
            trial = {r, w[QUO_W-1]};
            w = {w[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, src_den[s]}) begin
               r    = RAT_B_W'(trial - {1'b0, src_den[s]});
               w[0] = 1'b1;
            end else begin
               r = trial[RAT_B_W-1:0];
            end
         end
         rem_in[s]  = r;
         work_in[s] = w;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
            den_ff[s]  <= src_den[s];
         end
      end
   end

   assign quotient = work_ff[DIV_STAGES-1];

endmodule

@@ rtl/core/lfa_front.sv @@
// ----------------------------------------------------------------------
// lfa_front
// accepts request beats, checks the parameters and builds a job:
// quarter symbol counts, reduced bandwidth ratio and payload symbol count
// ----------------------------------------------------------------------
module lfa_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lfa_pkg::lfa_req_type req_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lfa_pkg::lfa_job_type out_job
);
   import lfa_pkg::*;

   logic          vld_ff, vld_in;
   lfa_job_type   job_ff, job_in;
   logic          accept;
   lfa_ratio_type ratio;
   logic          bad;
   logic [BLK_W-1:0] blocks;
   logic [CR_W:0]    cr4;
   logic [CNT_W-1:0] count;
   logic [NUM_W-1:0] pre_n;

   assign req_ready = !vld_ff || out_ready;
   assign accept    = req_valid && req_ready;
   assign vld_in    = accept || (vld_ff && !out_ready);

   // parameter check and job build
   always_comb begin
      ratio  = lfa_bw_ratio(req_data.bandwidth_code);
      bad    = !ratio.known
               || (req_data.sf_code < SF_MIN)
               || (req_data.sf_code > SF_MAX)
               || (req_data.cr_code < CR_MIN)
               || (req_data.cr_code > CR_MAX);
      blocks = lfa_payload_blocks(req_data.sf_code, req_data.header_term,
                                  req_data.low_rate_optimize);
      cr4    = {1'b0, req_data.cr_code} + (CR_W+1)'(CR_BASE);
      count  = CNT_W'(PAYLOAD_HEAD) + CNT_W'(cr4) * CNT_W'(blocks);
      pre_n  = NUM_W'({req_data.preamble_symbols, 2'b00}) + NUM_W'(PREAMBLE_TAIL);

      job_in.pre_n   = pre_n;
      job_in.frame_n = pre_n + NUM_W'({count, 2'b00});
      job_in.num_a   = ratio.num_a;
      job_in.den_b   = ratio.den_b;
      job_in.shift   = req_data.sf_code;
      job_in.count   = count;
      job_in.err     = 1'b0;
      // invalid parameters: zero numerator and unit divisor give zero times
      if (bad) begin
         job_in.pre_n   = '0;
         job_in.frame_n = '0;
         job_in.num_a   = '0;
         job_in.den_b   = RAT_B_W'(1);
         job_in.shift   = '0;
         job_in.count   = '0;
         job_in.err     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_job   = job_ff;

endmodule

@@ rtl/core/lfa_queue.sv @@
// ----------------------------------------------------------------------
// lfa_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------
module lfa_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lfa_pkg::lfa_job_type in_job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lfa_pkg::lfa_job_type out_job
);
   import lfa_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   lfa_job_type   slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = (cnt_ff != CW'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

@@ rtl/core/lfa_back.sv @@
// ----------------------------------------------------------------------
// lfa_back
// three time lanes fed from one job, a valid line and the count and
// error flag carried alongside; the last stage is the response register
// ----------------------------------------------------------------------
module lfa_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lfa_pkg::lfa_job_type in_job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lfa_pkg::lfa_rsp_type out_data
);
   import lfa_pkg::*;

   logic [BACK_LAT-1:0] vld_ff, vld_in;
   lfa_side_type        side_ff [BACK_LAT];
   logic                advance;
   logic [QUO_W-1:0]    sym_q, pre_q, frm_q;

   // whole pipeline holds while the response beat waits
   assign advance  = !vld_ff[BACK_LAT-1] || out_ready;
   assign in_ready = advance;
   assign vld_in   = {vld_ff[BACK_LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // side values follow the lanes stage by stage
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= '{count: in_job.count, err: in_job.err};
         for (int i = 1; i < BACK_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   lfa_div_lane u_sym_lane (
      .clock    (clock),
      .enable   (advance),
      .num      (NUM_W'(SYMBOL_QUARTERS)),
      .num_a    (in_job.num_a),
      .den_b    (in_job.den_b),
      .shift    (in_job.shift),
      .quotient (sym_q)
   );

   lfa_div_lane u_pre_lane (
      .clock    (clock),
      .enable   (advance),
      .num      (in_job.pre_n),
      .num_a    (in_job.num_a),
      .den_b    (in_job.den_b),
      .shift    (in_job.shift),
      .quotient (pre_q)
   );

   lfa_div_lane u_frm_lane (
      .clock    (clock),
      .enable   (advance),
      .num      (in_job.frame_n),
      .num_a    (in_job.num_a),
      .den_b    (in_job.den_b),
      .shift    (in_job.shift),
      .quotient (frm_q)
   );

   assign out_valid                     = vld_ff[BACK_LAT-1];
   assign out_data.symbol_time          = sym_q[SYM_W-1:0];
   assign out_data.preamble_time        = pre_q[TIME_W-1:0];
   assign out_data.frame_time           = frm_q[TIME_W-1:0];
   assign out_data.payload_symbol_count = side_ff[BACK_LAT-1].count;
   assign out_data.param_error          = side_ff[BACK_LAT-1].err;

endmodule

@@ rtl/core/lfa_checker.sv @@
// ----------------------------------------------------------------------
// lfa_checker
// port level checks of the lora frame airtime block, bound to the top
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module lfa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input lfa_pkg::lfa_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input lfa_pkg::lfa_rsp_type rsp_data
);
   import lfa_pkg::*;

   // a stalled response beat stays up
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped while stalled")

   // a stalled response beat keeps its payload
   `ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp payload changed while stalled")

   // bad parameters give an all zero result
   `ASSERT_RST(a_err_zero, clock, reset, rsp_valid && rsp_data.param_error |-> (rsp_data.symbol_time == '0 && rsp_data.preamble_time == '0 && rsp_data.frame_time == '0 && rsp_data.payload_symbol_count == '0), "error result not zero")

   // good parameters: frame covers the preamble, preamble covers a symbol, payload count exceeds the head
   `ASSERT_RST(a_time_order, clock, reset, rsp_valid && !rsp_data.param_error |-> (rsp_data.frame_time >= rsp_data.preamble_time && rsp_data.preamble_time >= TIME_W'(rsp_data.symbol_time) && rsp_data.payload_symbol_count > CNT_W'(PAYLOAD_HEAD)), "airtime ordering broken")

   // nothing is offered right after reset
   `ASSERT_ALW(a_reset_idle, clock, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind lora_frame_airtime lfa_checker u_checker (.*);

@@ tb/sv/lora_frame_airtime_test.sv @@
// ----------------------------------------------------------------------
// lora_frame_airtime_test
// self-checking bench for the lora frame airtime block
//
// request beats are drawn mostly from legal radio settings with random
// preamble lengths and flags, plus some raw noise that hits the error
// path. every accepted request is run through a local airtime
// calculation, and each response beat is compared field by field with
// the oldest outstanding prediction. both channels idle at random,
// with some stretches at full rate.
// ----------------------------------------------------------------------
module lora_frame_airtime_test;
   import lfa_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RANDOM_BEATS  = 1130;
   localparam int CHUNK_BEATS   = 113;
   localparam int DRAIN_CYCLES  = 40;
   localparam int MAX_IDLE      = 15;

   // frame constants of the airtime formula
   localparam longint unsigned FRAME_BYTES  = 256;
   localparam longint unsigned CRC_HDR_BITS = 44;
   localparam longint unsigned EXPLICIT_HDR = 20;
   localparam longint unsigned US_Q8        = 64'd256000000;

   // keeps predicted responses in acceptance order and checks them
   class airtime_board;
      lfa_rsp_type airtime_q[$];
      int          errors;
      int          checked;
      int          flagged;

      function new();
         errors  = 0;
         checked = 0;
         flagged = 0;
      endfunction

      // bandwidth code to hertz, zero for unknown codes
      function longint unsigned code_to_hz(logic [BW_CODE_W-1:0] code);
         longint unsigned hz;
         case (code)
            BW_7K81:  hz = 7810;
            BW_15K63: hz = 15630;
            BW_31K25: hz = 31250;
            BW_62K5:  hz = 62500;
            BW_125K:  hz = 125000;
            BW_250K:  hz = 250000;
            BW_500K:  hz = 500000;
            BW_10K42: hz = 10420;
            BW_20K83: hz = 20830;
            BW_41K67: hz = 41670;
            default:  hz = 0;
         endcase
         return hz;
      endfunction

      // exact rational airtimes, truncated to us with 8 fraction bits
      function lfa_rsp_type predict_airtime(lfa_req_type r);
         lfa_rsp_type     o;
         longint unsigned hz, sf, cr, hdr, ldro, scale, num, den, blocks, count, pre_q;
         o    = '0;
         hz   = code_to_hz(r.bandwidth_code);
         sf   = 64'(r.sf_code);
         cr   = 64'(r.cr_code);
         hdr  = 64'(r.header_term);
         ldro = 64'(r.low_rate_optimize);
         if (hz == 0 || r.sf_code < SF_MIN || r.sf_code > SF_MAX ||
             r.cr_code < CR_MIN || r.cr_code > CR_MAX) begin
            o.param_error = 1'b1;
            return o;
         end
         scale  = (64'd1 << sf) * US_Q8;
         num    = 8 * FRAME_BYTES + CRC_HDR_BITS + EXPLICIT_HDR * hdr - 4 * sf;
         den    = SYMBOL_QUARTERS * (sf - 2 * ldro);
         blocks = (num + den - 1) / den;
         count  = PAYLOAD_HEAD + (cr + CR_BASE) * blocks;
         pre_q  = SYMBOL_QUARTERS * longint'(r.preamble_symbols) + PREAMBLE_TAIL;
         o.symbol_time          = SYM_W'(scale / hz);
         o.preamble_time        = TIME_W'((pre_q * scale) / (SYMBOL_QUARTERS * hz));
         o.frame_time           = TIME_W'(((pre_q + SYMBOL_QUARTERS * count) * scale) /
                                          (SYMBOL_QUARTERS * hz));
         o.payload_symbol_count = CNT_W'(count);
         return o;
      endfunction

      // accepted request beat
      function void note_request(lfa_req_type r);
         airtime_q.push_back(predict_airtime(r));
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      // accepted response beat
      function void check_response(lfa_rsp_type got);
         lfa_rsp_type want;
         if (airtime_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         want = airtime_q.pop_front();
         checked++;
         if (want.param_error) flagged++;
         compare_field("symbol_time", want.symbol_time, got.symbol_time);
         compare_field("preamble_time", want.preamble_time, got.preamble_time);
         compare_field("frame_time", want.frame_time, got.frame_time);
         compare_field("payload_symbol_count", want.payload_symbol_count,
                       got.payload_symbol_count);
         compare_field("param_error", want.param_error, got.param_error);
      endfunction

      function int pending();
         return airtime_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   lfa_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   lfa_rsp_type rsp_data;

   airtime_board board;
   bit           send_idle;
   bit           recv_idle;
   int           sent;

   lora_frame_airtime u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      sent      = 0;
      board     = new();
   end

   // hard stop well past the slowest legal run
   initial begin
      #8000000;
      $display("FAILED: results differ");
      $finish;
   end

   // one request beat, after an optional gap with valid low
   task automatic send_request(lfa_req_type d);
      int gap;
      gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      board.note_request(d);
      sent++;
   endtask

   function automatic lfa_req_type make_request(logic [SF_W-1:0] sf, logic [BW_CODE_W-1:0] bw,
                                                logic [CR_W-1:0] cr, logic [PRE_W-1:0] pre,
                                                logic hdr, logic ldro);
      lfa_req_type r;
      r.sf_code           = sf;
      r.bandwidth_code    = bw;
      r.cr_code           = cr;
      r.preamble_symbols  = pre;
      r.header_term       = hdr;
      r.low_rate_optimize = ldro;
      return r;
   endfunction

   // legal settings most of the time, raw noise otherwise
   function automatic lfa_req_type random_request();
      logic [BW_CODE_W-1:0] legal_bw[10];
      lfa_req_type          r;
      int                   pick;
      legal_bw = '{BW_7K81, BW_15K63, BW_31K25, BW_62K5, BW_125K, BW_250K, BW_500K,
                   BW_10K42, BW_20K83, BW_41K67};
      if ($urandom_range(0, 99) < 80) begin
         r.sf_code        = SF_W'($urandom_range(SF_MIN, SF_MAX));
         r.bandwidth_code = legal_bw[$urandom_range(0, 9)];
         r.cr_code        = CR_W'($urandom_range(CR_MIN, CR_MAX));
      end else begin
         r.sf_code        = SF_W'($urandom_range(0, 15));
         r.bandwidth_code = BW_CODE_W'($urandom_range(0, 15));
         r.cr_code        = CR_W'($urandom_range(0, 7));
      end
      pick = $urandom_range(0, 7);
      if (pick < 2)       r.preamble_symbols = PRE_W'($urandom_range(0, 31));
      else if (pick == 2) r.preamble_symbols = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else                r.preamble_symbols = PRE_W'($urandom_range(0, 65535));
      r.header_term       = 1'($urandom_range(0, 1));
      r.low_rate_optimize = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // response side, stalls drawn per beat
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_response(rsp_data);
      end
   end

   // main sequence
   initial begin
      int i;
      int mode;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of the legal range
      send_request(make_request(SF_MIN, BW_125K, CR_MIN, 16'd0, 1'b0, 1'b0));
      send_request(make_request(SF_MAX, BW_7K81, CR_MAX, 16'hFFFF, 1'b1, 1'b1));
      send_request(make_request(SF_MAX, BW_500K, CR_MAX, 16'd8, 1'b1, 1'b0));
      send_request(make_request(SF_MIN, BW_7K81, CR_MAX, 16'hFFFF, 1'b1, 1'b1));
      // every remaining known bandwidth
      send_request(make_request(4'd7, BW_15K63, 3'd2, 16'd12, 1'b0, 1'b1));
      send_request(make_request(4'd8, BW_31K25, 3'd3, 16'd6, 1'b1, 1'b0));
      send_request(make_request(4'd9, BW_62K5, 3'd1, 16'd100, 1'b0, 1'b0));
      send_request(make_request(4'd10, BW_250K, 3'd4, 16'd8, 1'b1, 1'b1));
      send_request(make_request(4'd11, BW_10K42, 3'd2, 16'd32768, 1'b0, 1'b1));
      send_request(make_request(4'd6, BW_20K83, 3'd3, 16'd1, 1'b1, 1'b0));
      send_request(make_request(4'd12, BW_41K67, 3'd1, 16'd4095, 1'b0, 1'b1));
      // unknown bandwidth codes
      send_request(make_request(4'd7, 4'd7, 3'd1, 16'd8, 1'b0, 1'b0));
      send_request(make_request(4'd7, 4'd11, 3'd1, 16'd8, 1'b0, 1'b0));
      send_request(make_request(4'd7, 4'd15, 3'd1, 16'd8, 1'b0, 1'b0));
      // spreading factor out of range
      send_request(make_request(4'd0, BW_125K, 3'd1, 16'd8, 1'b0, 1'b0));
      send_request(make_request(4'd4, BW_125K, 3'd1, 16'd8, 1'b1, 1'b1));
      send_request(make_request(4'd13, BW_125K, 3'd1, 16'd8, 1'b0, 1'b0));
      send_request(make_request(4'd15, BW_125K, 3'd4, 16'hFFFF, 1'b1, 1'b1));
      // coding rate out of range
      send_request(make_request(4'd7, BW_125K, 3'd0, 16'd8, 1'b0, 1'b0));
      send_request(make_request(4'd7, BW_125K, 3'd5, 16'd8, 1'b0, 1'b0));
      send_request(make_request(4'd7, BW_125K, 3'd7, 16'd8, 1'b1, 1'b1));

      // random beats in chunks with changing idle patterns
      for (i = 0; i < RANDOM_BEATS; i++) begin
         if (i % CHUNK_BEATS == 0) begin
            mode = (i / CHUNK_BEATS) % 4;
            send_idle = (mode == 0 || mode == 2);
            recv_idle = (mode == 0 || mode == 3);
         end
         // let the pipe run dry once mid-run
         if (i == 3 * CHUNK_BEATS) begin
            req_valid <= 1'b0;
            while (board.pending() != 0) @(posedge clock);
         end
         send_request(random_request());
      end
      req_valid <= 1'b0;
      recv_idle = 1'b1;

      // drain, then watch for stray beats
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request beats, checked %0d responses (%0d with bad parameters)",
               sent, board.checked, board.flagged);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
